@@ rtl/ipid_pkg.sv @@
// Shared constants and types for the incremental PID controller.
`default_nettype none

package ipid_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int SETPOINT_W = 12;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 10;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT = 3'd0,
        CFG_GAIN_K1  = 3'd1,
        CFG_GAIN_K2  = 3'd2,
        CFG_GAIN_K3  = 3'd3,
        CFG_OUT_MIN  = 3'd4,
        CFG_OUT_MAX  = 3'd5
    } t_cfg_idx;

    localparam logic [SETPOINT_W-1:0]    SETPOINT_RST = 12'd0;
    localparam logic signed [GAIN_W-1:0] GAIN_K1_RST  = 16'sd320;
    localparam logic signed [GAIN_W-1:0] GAIN_K2_RST  = -16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_K3_RST  = 16'sd0;
    localparam logic [DRIVE_W-1:0]       OUT_MIN_RST  = 10'd0;
    localparam logic [DRIVE_W-1:0]       OUT_MAX_RST  = 10'd1023;

endpackage

`default_nettype wire

@@ rtl/incremental_pid_fixed_point.sv @@
// Top level of the incremental (velocity-form) PID controller.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_sample
//  out      | source    | o_out_valid/i_out_stall | o_drive, o_clamped
//  cfg      | sink      | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One sample per cycle while the output is not stalled. A sample is held in the
// input register; the three products, their sum, the shift, the add and the
// clamp run combinationally from there into the result register.
// Synchronous active-low reset loads the config defaults and clears error history and previous drive.
// A stall on the output holds the result register and the input register;
// the input still takes a transfer while the held sample can move on.
`default_nettype none

module incremental_pid_fixed_point #(
    parameter int FRAC_BITS   = ipid_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = ipid_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ipid_pkg::DRIVE_W-1:0]       o_drive,
    output logic                               o_clamped,
    input  wire logic                          i_cfg_we,
    input  wire logic [ipid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ipid_pkg::CFG_W-1:0]    i_cfg_data
);
    import ipid_pkg::*;

    localparam int SP_W = (SAMPLE_BITS < SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W;
    localparam int EW   = SAMPLE_BITS + 1;   // error width
    localparam int PW   = GAIN_W + EW;       // product width
    localparam int SW   = PW + 2;            // sum of three products
    localparam int YW   = SW + 1;            // after adding previous drive

    // configuration
    logic [SETPOINT_W-1:0]    r_setpoint;
    logic signed [GAIN_W-1:0] r_k1, r_k2, r_k3;
    logic [DRIVE_W-1:0]       r_out_min, r_out_max;

    // pipeline and state
    logic                     r_in_valid;
    logic [SAMPLE_BITS-1:0]   r_sample;
    logic                     r_out_valid;
    logic [DRIVE_W-1:0]       r_drive;
    logic                     r_clamped;
    logic signed [EW-1:0]     r_prev_error, r_older_error;
    logic [DRIVE_W-1:0]       r_prev_drive;

    logic                     w_advance;
    logic [SAMPLE_BITS-1:0]   w_sp;
    logic signed [EW-1:0]     w_err;
    logic signed [PW-1:0]     w_p1, w_p2, w_p3;
    logic signed [SW-1:0]     w_sum, w_inc;
    logic signed [YW-1:0]     w_y, w_pd, w_min, w_max;
    logic [DRIVE_W-1:0]       n_drive;
    logic                     n_clamped;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= SETPOINT_RST;
            r_k1       <= GAIN_K1_RST;
            r_k2       <= GAIN_K2_RST;
            r_k3       <= GAIN_K3_RST;
            r_out_min  <= OUT_MIN_RST;
            r_out_max  <= OUT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SETPOINT: r_setpoint <= i_cfg_data[SETPOINT_W-1:0];
                CFG_GAIN_K1:  r_k1       <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_GAIN_K2:  r_k2       <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_GAIN_K3:  r_k3       <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_OUT_MIN:  r_out_min  <= i_cfg_data[DRIVE_W-1:0];
                CFG_OUT_MAX:  r_out_max  <= i_cfg_data[DRIVE_W-1:0];
                default: ;   // writes past the last register are dropped
            endcase
        end
    end

    // error and weighted sum, kept at full width so nothing wraps
    assign w_sp  = SAMPLE_BITS'(r_setpoint[SP_W-1:0]);
    assign w_err = $signed({1'b0, w_sp}) - $signed({1'b0, r_sample});
    assign w_p1  = r_k1 * w_err;
    assign w_p2  = r_k2 * r_prev_error;
    assign w_p3  = r_k3 * r_older_error;
    assign w_sum = SW'(w_p1) + SW'(w_p2) + SW'(w_p3);
    assign w_inc = w_sum >>> FRAC_BITS;   // floor

    assign w_pd  = YW'({1'b0, r_prev_drive});
    assign w_min = YW'({1'b0, r_out_min});
    assign w_max = YW'({1'b0, r_out_max});
    assign w_y   = YW'(w_inc) + w_pd;

    // upper limit is checked first; when the limits cross, a value above it gets the upper limit, any other the lower
    always_comb begin
        priority if (w_y > w_max) begin
            n_drive   = r_out_max;
            n_clamped = 1'b1;
        end else if (w_y < w_min) begin
            n_drive   = r_out_min;
            n_clamped = 1'b1;
        end else begin
            n_drive   = w_y[DRIVE_W-1:0];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev_error  <= '0;
            r_older_error <= '0;
            r_prev_drive  <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid   <= 1'b1;
                r_prev_error  <= w_err;
                r_older_error <= r_prev_error;
                r_prev_drive  <= n_drive;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_sample <= i_sample;
        end
        if (w_advance) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

`ifndef SYNTHESIS
    a_drive_fed_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_prev_drive == o_drive)
        else $error("previous drive differs from the transferred result");

    a_error_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_prev_error == $past(w_err) && r_older_error == $past(r_prev_error))
        else $error("error history not shifted on advance");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_prev_drive) && $stable(r_prev_error))
        else $error("controller state changed without a sample");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && n_clamped |-> n_drive == r_out_max || n_drive == r_out_min)
        else $error("clamped drive is not a limit");
`endif

endmodule

`default_nettype wire
